@@ hdl/assert_macros.svh @@
// Assertion helpers, clocked on clk and disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/btnc_pkg.sv @@
`timescale 1ns / 1ps

package btnc_pkg;

  // Field widths
  localparam int unsigned TS_W     = 32;
  localparam int unsigned MS_W     = 16;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned APB_AW   = 5;
  localparam int unsigned REG_IDX_W = 3;

  // Register indexes (byte address = 4 * index)
  localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE_TIME   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TAP_MIN_TIME    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_HOLD_TIME       = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ACTIVE_LOW      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BUTTON_DISABLED = 3'd4;

  // Reset values of the registers
  localparam logic [MS_W-1:0] DEBOUNCE_TIME_RST = 16'd30;
  localparam logic [MS_W-1:0] TAP_MIN_TIME_RST  = 16'd50;
  localparam logic [MS_W-1:0] HOLD_TIME_RST     = 16'd800;

  // Event codes
  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_TAP  = 2'd1,
    EV_HOLD = 2'd2
  } event_t;

  // Configuration bundle from the register block to the core
  typedef struct packed {
    logic [MS_W-1:0] debounce_time;
    logic [MS_W-1:0] tap_min_time;
    logic [MS_W-1:0] hold_time;
    logic            active_low;
    logic            button_disabled;
  } cfg_t;

endpackage

@@ hdl/btnc_poll_if.sv @@
`timescale 1ns / 1ps

// Poll request channel: raw pin level plus timestamp
interface btnc_poll_if;
  logic        valid;
  logic        ready;
  logic        raw_level;
  logic [31:0] now_ms;

  modport source (output valid, output raw_level, output now_ms, input ready);
  modport sink (input valid, input raw_level, input now_ms, output ready);
endinterface

@@ hdl/btnc_result_if.sv @@
`timescale 1ns / 1ps

// Result request channel: event code plus debounced level
interface btnc_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic       pressed;

  modport source (output valid, output event_res, output pressed, input ready);
  modport sink (input valid, input event_res, input pressed, output ready);
endinterface

@@ hdl/btnc_cfg.sv @@
`timescale 1ns / 1ps

module btnc_cfg import btnc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[APB_AW-1:2];

  // Register writes; unmapped indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_time   <= DEBOUNCE_TIME_RST;
      cfg.tap_min_time    <= TAP_MIN_TIME_RST;
      cfg.hold_time       <= HOLD_TIME_RST;
      cfg.active_low      <= 1'b1;
      cfg.button_disabled <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        REG_DEBOUNCE_TIME:   cfg.debounce_time   <= pwdata[MS_W-1:0];
        REG_TAP_MIN_TIME:    cfg.tap_min_time    <= pwdata[MS_W-1:0];
        REG_HOLD_TIME:       cfg.hold_time       <= pwdata[MS_W-1:0];
        REG_ACTIVE_LOW:      cfg.active_low      <= pwdata[0];
        REG_BUTTON_DISABLED: cfg.button_disabled <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_DEBOUNCE_TIME:   prdata = {{(APB_DW-MS_W){1'b0}}, cfg.debounce_time};
      REG_TAP_MIN_TIME:    prdata = {{(APB_DW-MS_W){1'b0}}, cfg.tap_min_time};
      REG_HOLD_TIME:       prdata = {{(APB_DW-MS_W){1'b0}}, cfg.hold_time};
      REG_ACTIVE_LOW:      prdata = {{(APB_DW-1){1'b0}}, cfg.active_low};
      REG_BUTTON_DISABLED: prdata = {{(APB_DW-1){1'b0}}, cfg.button_disabled};
      default:             prdata = '0;
    endcase
  end

endmodule

@@ hdl/btnc_core.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module btnc_core import btnc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic            raw_level,
  input  logic [TS_W-1:0] now_ms,
  input  cfg_t            cfg,
  output event_t          res_event,
  output logic            res_pressed
);

  // Debounce / press tracking state
  logic            last_level, last_level_next;
  logic            last_level_valid, last_level_valid_next;
  logic            stable_level, stable_level_next;
  logic            stable_valid, stable_valid_next;
  logic [TS_W-1:0] change_time, change_time_next;
  logic [TS_W-1:0] press_time, press_time_next;
  logic            hold_reported, hold_reported_next;
  logic            pressed_flag, pressed_flag_next;
  event_t          ev_next;

  logic            level_chg, stable_chg, db_ok, was_pressed, is_pressed, press_start;
  logic [TS_W-1:0] ct_sel, elapsed, pt_sel, press_len;

  // Raw change restarts the debounce window
  assign level_chg = !last_level_valid || (raw_level != last_level);
  assign ct_sel    = level_chg ? now_ms : change_time;
  assign elapsed   = now_ms - ct_sel;
  assign db_ok     = !elapsed[TS_W-1] &&
                     (elapsed >= {{(TS_W-MS_W){1'b0}}, cfg.debounce_time});

  // Stable level transitions, polarity applied
  assign stable_chg  = !stable_valid || (raw_level != stable_level);
  assign was_pressed = stable_valid && (stable_level ^ cfg.active_low);
  assign is_pressed  = raw_level ^ cfg.active_low;
  assign press_start = db_ok && stable_chg && is_pressed && !was_pressed;

  // Press length against the press start that holds after this poll
  assign pt_sel    = press_start ? now_ms : press_time;
  assign press_len = now_ms - pt_sel;

  always_comb begin
    last_level_next       = last_level;
    last_level_valid_next = last_level_valid;
    stable_level_next     = stable_level;
    stable_valid_next     = stable_valid;
    change_time_next      = change_time;
    press_time_next       = pt_sel;
    hold_reported_next    = hold_reported;
    pressed_flag_next     = pressed_flag;
    ev_next               = EV_NONE;
    if (cfg.button_disabled) begin
      pressed_flag_next = 1'b0;
      press_time_next   = press_time;
    end else begin
      last_level_next       = raw_level;
      last_level_valid_next = 1'b1;
      change_time_next      = ct_sel;
      if (db_ok) begin
        if (stable_chg) begin
          stable_level_next = raw_level;
          stable_valid_next = 1'b1;
          pressed_flag_next = is_pressed;
          if (press_start) begin
            hold_reported_next = 1'b0;
          end else if (!is_pressed && was_pressed && !hold_reported &&
                       (press_len >= {{(TS_W-MS_W){1'b0}}, cfg.tap_min_time})) begin
            ev_next = EV_TAP;
          end
        end else begin
          pressed_flag_next = stable_level ^ cfg.active_low;
        end
      end
      // Single hold event per press
      if (pressed_flag_next && !hold_reported_next &&
          (press_len >= {{(TS_W-MS_W){1'b0}}, cfg.hold_time})) begin
        ev_next            = EV_HOLD;
        hold_reported_next = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_level       <= 1'b0;
      last_level_valid <= 1'b0;
      stable_level     <= 1'b0;
      stable_valid     <= 1'b0;
      change_time      <= '0;
      press_time       <= '0;
      hold_reported    <= 1'b0;
      pressed_flag     <= 1'b0;
    end else if (step) begin
      last_level       <= last_level_next;
      last_level_valid <= last_level_valid_next;
      stable_level     <= stable_level_next;
      stable_valid     <= stable_valid_next;
      change_time      <= change_time_next;
      press_time       <= press_time_next;
      hold_reported    <= hold_reported_next;
      pressed_flag     <= pressed_flag_next;
    end
  end

  // Result register (payload)
  always_ff @(posedge clk) begin
    if (step) begin
      res_event   <= ev_next;
      res_pressed <= pressed_flag_next;
    end
  end

  `ASSERT_NXT(a_dis_quiet, step && cfg.button_disabled, !pressed_flag && (res_event == EV_NONE), "disabled poll must give no event and clear pressed")
  `ASSERT_NXT(a_pressed_match, step, res_pressed == pressed_flag, "result pressed differs from tracked state")
  `ASSERT_NXT(a_hold_once, step && hold_reported && !press_start, res_event != EV_HOLD, "second hold event in one press")
  `ASSERT_NXT(a_hold_marks, step && (ev_next == EV_HOLD), hold_reported, "hold event without hold mark")

endmodule

@@ hdl/button_tap_hold_classifier.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Channel   Dir  Payload                         Handshake
// poll      in   raw_level[0], now_ms[31:0]      valid/ready
// result    out  event_res[1:0], pressed[0]      valid/ready
// APB       in   paddr[4:2] index, pwdata[31:0]  psel/penable/pwrite, pready=1
//
// One poll per clock while the result is not stalled: poll register, then classify logic
// into the result register. An accepted poll is held in the poll register, then its result
// is registered in the result register and shown as result valid.
// rst (synchronous) clears all tracking state and loads register defaults.
// A stalled result holds both stages; poll ready drops only when both are full.

module button_tap_hold_classifier import btnc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  btnc_poll_if.sink         poll,
  btnc_result_if.source     result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t            cfg;
  logic            stg_valid;
  logic            stg_raw;
  logic [TS_W-1:0] stg_now;
  logic            out_valid;
  logic            adv;
  event_t          res_event;
  logic            res_pressed;

  btnc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Stage moves into the result register when that is free or draining
  assign adv        = stg_valid && (!out_valid || result.ready);
  assign poll.ready = !stg_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (poll.ready) begin
        stg_valid <= poll.valid;
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Poll register
  always_ff @(posedge clk) begin
    if (poll.valid && poll.ready) begin
      stg_raw <= poll.raw_level;
      stg_now <= poll.now_ms;
    end
  end

  btnc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (adv),
    .raw_level   (stg_raw),
    .now_ms      (stg_now),
    .cfg         (cfg),
    .res_event   (res_event),
    .res_pressed (res_pressed)
  );

  assign result.valid     = out_valid;
  assign result.event_res = res_event;
  assign result.pressed   = res_pressed;

  `ASSERT_NXT(a_stage_hold, stg_valid && !adv, stg_valid, "poll stage lost while stalled")
  `ASSERT_IMP(a_no_overrun, out_valid && !result.ready, !adv, "result overwritten while stalled")

endmodule

@@ tb/button_tap_hold_classifier_test.sv @@
`timescale 1ns / 1ps

module button_tap_hold_classifier_test;
  import btnc_pkg::*;

  localparam int unsigned CLK_HALF        = 10;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned HOLD_OFF_CYCLES = 80;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned RANDOM_POLLS    = 400;
  // Addresses past the last register; writes there must change nothing
  localparam logic [REG_IDX_W-1:0] REG_UNUSED_FIRST = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED_LAST  = 3'd7;

  typedef struct {
    logic            raw_level;
    logic [TS_W-1:0] now_ms;
  } poll_t;

  typedef struct {
    event_t event_res;
    logic   pressed;
  } report_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  btnc_poll_if   poll_ch ();
  btnc_result_if result_ch ();

  button_tap_hold_classifier uut (
    .clk     (clk),
    .rst     (rst),
    .poll    (poll_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Polls waiting to be sent, and predicted reports waiting to come back
  poll_t   poll_backlog[$];
  report_t button_reports[$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          poll_taken = 1'b0;
  bit          steady_tx = 1'b0;
  bit          hold_off_req = 1'b0;
  logic [TS_W-1:0] ts;

  // Shadow of the registers and of the classifier state
  cfg_t            shadow_cfg;
  logic            prev_raw;
  logic            prev_raw_seen;
  logic            settled_level;
  logic            settled_seen;
  logic            hold_sent;
  logic            down_flag;
  logic [TS_W-1:0] raw_change_ms;
  logic [TS_W-1:0] press_start_ms;

  function automatic logic level_down(input logic lvl);
    return shadow_cfg.active_low ? ~lvl : lvl;
  endfunction

  // Debounce one poll and classify it into tap / hold / none
  function automatic report_t classify_poll(input logic raw, input logic [TS_W-1:0] now);
    report_t         rep;
    logic [TS_W-1:0] since_change;
    logic [TS_W-1:0] held_ms;
    logic            was_down;
    logic            is_down;
    rep.event_res = EV_NONE;
    rep.pressed = 1'b0;
    if (shadow_cfg.button_disabled) begin
      down_flag = 1'b0;
      return rep;
    end
    if (!prev_raw_seen || raw != prev_raw) begin
      prev_raw = raw;
      prev_raw_seen = 1'b1;
      raw_change_ms = now;
    end
    since_change = now - raw_change_ms;
    // negative difference means time went backwards: not settled
    if (!since_change[TS_W-1] && since_change >= shadow_cfg.debounce_time) begin
      if (!settled_seen || raw != settled_level) begin
        was_down = settled_seen && level_down(settled_level);
        settled_level = raw;
        settled_seen = 1'b1;
        is_down = level_down(raw);
        down_flag = is_down;
        held_ms = now - press_start_ms;
        if (is_down && !was_down) begin
          press_start_ms = now;
          hold_sent = 1'b0;
        end else if (!is_down && was_down && !hold_sent &&
                     held_ms >= shadow_cfg.tap_min_time) begin
          rep.event_res = EV_TAP;
        end
      end else begin
        down_flag = level_down(settled_level);
      end
    end
    held_ms = now - press_start_ms;
    if (down_flag && !hold_sent && held_ms >= shadow_cfg.hold_time) begin
      rep.event_res = EV_HOLD;
      hold_sent = 1'b1;
    end
    rep.pressed = down_flag;
    return rep;
  endfunction

  function automatic logic [APB_DW-1:0] reg_image(input logic [REG_IDX_W-1:0] idx);
    logic [APB_DW-1:0] img;
    img = '0;
    case (idx)
      REG_DEBOUNCE_TIME:   img[MS_W-1:0] = shadow_cfg.debounce_time;
      REG_TAP_MIN_TIME:    img[MS_W-1:0] = shadow_cfg.tap_min_time;
      REG_HOLD_TIME:       img[MS_W-1:0] = shadow_cfg.hold_time;
      REG_ACTIVE_LOW:      img[0] = shadow_cfg.active_low;
      REG_BUTTON_DISABLED: img[0] = shadow_cfg.button_disabled;
      default:             img = '0;
    endcase
    return img;
  endfunction

  // APB write, then read back and compare (mapped registers only)
  task automatic set_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    case (idx)
      REG_DEBOUNCE_TIME:   shadow_cfg.debounce_time = value[MS_W-1:0];
      REG_TAP_MIN_TIME:    shadow_cfg.tap_min_time = value[MS_W-1:0];
      REG_HOLD_TIME:       shadow_cfg.hold_time = value[MS_W-1:0];
      REG_ACTIVE_LOW:      shadow_cfg.active_low = value[0];
      REG_BUTTON_DISABLED: shadow_cfg.button_disabled = value[0];
      default: ;
    endcase
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (idx <= REG_BUTTON_DISABLED && prdata !== reg_image(idx)) begin
      $display("%0t: register %0d readback mismatch: expected %h, actual %h",
               $time, idx, reg_image(idx), prdata);
      error_count++;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic configure(input int unsigned deb, input int unsigned tap,
                           input int unsigned hold, input logic low, input logic dis);
    set_reg(REG_DEBOUNCE_TIME, deb);
    set_reg(REG_TAP_MIN_TIME, tap);
    set_reg(REG_HOLD_TIME, hold);
    set_reg(REG_ACTIVE_LOW, low);
    set_reg(REG_BUTTON_DISABLED, dis);
  endtask

  task automatic queue_poll(input logic raw, input logic [TS_W-1:0] now);
    ts = now;
    poll_backlog.push_back('{raw, now});
  endtask

  task automatic add_poll(input logic raw, input int unsigned step_ms);
    queue_poll(raw, ts + step_ms);
  endtask

  // Human-like press: contact bounce, hold, bounce, then rest long enough to settle
  task automatic add_press(input int unsigned hold_ms);
    logic        down;
    int unsigned held;
    int unsigned step_max;
    int unsigned span;
    down = shadow_cfg.active_low ? 1'b0 : 1'b1;
    repeat ($urandom_range(0, 3)) add_poll(1'($urandom), $urandom_range(1, 3));
    span = hold_ms + shadow_cfg.debounce_time;
    step_max = span / 5 + 1;
    held = 0;
    do begin
      step_max = (step_max == 0) ? 1 : step_max;
      add_poll(down, $urandom_range(1, step_max));
      held = ts - poll_backlog[$].now_ms + held;
      held += 0;
    end while (0);
    held = 0;
    while (held < span) begin
      int unsigned s;
      s = $urandom_range(1, step_max);
      add_poll(down, s);
      held += s;
    end
    repeat ($urandom_range(0, 3)) add_poll(1'($urandom), $urandom_range(1, 3));
    span = shadow_cfg.debounce_time + $urandom_range(0, 20);
    step_max = span / 3 + 1;
    held = 0;
    while (held < span) begin
      int unsigned s;
      s = $urandom_range(1, step_max);
      add_poll(~down, s);
      held += s;
    end
  endtask

  // Wait until nothing is queued, on the wire or outstanding; checked at the
  // rising edge, where the sender's outputs are settled
  task automatic drain();
    while (poll_backlog.size() != 0 || poll_ch.valid || button_reports.size() != 0)
      @(posedge clk);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run limit reached", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Poll sender: bursts of random length with random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  poll_t       next_poll;

  always @(negedge clk) begin
    if (rst) begin
      poll_ch.valid <= 1'b0;
    end else if (!poll_ch.valid || poll_taken) begin
      if (gap_left != 0) begin
        gap_left--;
        poll_ch.valid <= 1'b0;
      end else if (poll_backlog.size() != 0) begin
        next_poll = poll_backlog.pop_front();
        poll_ch.valid <= 1'b1;
        poll_ch.raw_level <= next_poll.raw_level;
        poll_ch.now_ms <= next_poll.now_ms;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 16);
          gap_left = steady_tx ? 0 : $urandom_range(0, 6);
        end
      end else begin
        poll_ch.valid <= 1'b0;
      end
    end
    poll_taken = 1'b0;
  end

  // Result receiver: rotating stall pattern, plus a long hold-off on request
  int unsigned hold_left = 0;
  int unsigned pat_left = 0;
  logic [15:0] stall_pat;

  always @(negedge clk) begin
    if (hold_off_req) begin
      hold_left = HOLD_OFF_CYCLES;
      hold_off_req = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      result_ch.ready <= 1'b0;
    end else begin
      if (pat_left == 0) begin
        stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
        pat_left = 16;
      end
      result_ch.ready <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[15:1]};
      pat_left--;
    end
  end

  // Monitor: predict on poll accept, compare on result accept
  report_t seen_report;

  always @(posedge clk) begin
    if (!rst) begin
      if (poll_ch.valid && poll_ch.ready) begin
        button_reports.push_back(classify_poll(poll_ch.raw_level, poll_ch.now_ms));
        poll_taken = 1'b1;
      end
      if (result_ch.valid && result_ch.ready) begin
        if (button_reports.size() == 0) begin
          $display("%0t: unexpected result: event_res %0d pressed %b",
                   $time, result_ch.event_res, result_ch.pressed);
          error_count++;
        end else begin
          seen_report = button_reports.pop_front();
          if (result_ch.event_res !== seen_report.event_res) begin
            $display("%0t: event_res mismatch: expected %0d, actual %0d",
                     $time, seen_report.event_res, result_ch.event_res);
            error_count++;
          end
          if (result_ch.pressed !== seen_report.pressed) begin
            $display("%0t: pressed mismatch: expected %b, actual %b",
                     $time, seen_report.pressed, result_ch.pressed);
            error_count++;
          end
        end
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned phase;
    int unsigned random_polls;
    int unsigned target;
    logic        dis_phase;

    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    poll_ch.valid = 1'b0;
    poll_ch.raw_level = 1'b0;
    poll_ch.now_ms = '0;
    result_ch.ready = 1'b0;
    shadow_cfg.debounce_time = DEBOUNCE_TIME_RST;
    shadow_cfg.tap_min_time = TAP_MIN_TIME_RST;
    shadow_cfg.hold_time = HOLD_TIME_RST;
    shadow_cfg.active_low = 1'b1;
    shadow_cfg.button_disabled = 1'b0;
    prev_raw = 1'b0;
    prev_raw_seen = 1'b0;
    settled_level = 1'b0;
    settled_seen = 1'b0;
    hold_sent = 1'b0;
    down_flag = 1'b0;
    raw_change_ms = '0;
    press_start_ms = '0;
    ts = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset settings: first sample, settle, tap, too-short press, hold, no tap after hold
    queue_poll(1'b1, 32'd0);
    queue_poll(1'b1, 32'd40);
    queue_poll(1'b0, 32'd50);
    queue_poll(1'b0, 32'd90);
    queue_poll(1'b1, 32'd210);
    queue_poll(1'b1, 32'd250);
    queue_poll(1'b0, 32'd300);
    queue_poll(1'b0, 32'd340);
    queue_poll(1'b1, 32'd350);
    queue_poll(1'b1, 32'd385);
    queue_poll(1'b0, 32'd400);
    queue_poll(1'b0, 32'd440);
    queue_poll(1'b0, 32'd1240);
    queue_poll(1'b1, 32'd1310);
    queue_poll(1'b1, 32'd1350);
    // time going backwards, then wrap through zero
    queue_poll(1'b0, 32'd1360);
    queue_poll(1'b0, 32'd1000);
    queue_poll(1'b1, 32'hFFFF_FFFF);
    queue_poll(1'b1, 32'h0000_001E);
    drain();

    // All times zero, active high: stored level reinterpreted, instant hold
    configure(0, 0, 0, 1'b0, 1'b0);
    set_reg(REG_UNUSED_FIRST, $urandom());
    set_reg(REG_UNUSED_LAST, $urandom());
    queue_poll(1'b1, 32'd5000);
    queue_poll(1'b0, 32'd5001);
    queue_poll(1'b1, 32'd5002);
    queue_poll(1'b0, 32'd5002);
    drain();

    // All times at maximum
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    queue_poll(1'b0, 32'h0001_0000);
    queue_poll(1'b0, 32'h0001_FFFF);
    drain();

    // Polarity flipped while pressed
    configure(5, 10, 1000, 1'b1, 1'b0);
    queue_poll(1'b0, 32'h0004_0005);
    drain();
    set_reg(REG_ACTIVE_LOW, 1'b0);
    queue_poll(1'b0, 32'h0004_0010);
    drain();

    // Disabled, then enabled again
    set_reg(REG_BUTTON_DISABLED, 1'b1);
    queue_poll(1'b1, 32'h0004_0020);
    drain();
    set_reg(REG_BUTTON_DISABLED, 1'b0);
    queue_poll(1'b0, 32'h0004_0040);
    drain();

    // Random press sequences with noise, one setting per phase
    phase = 0;
    random_polls = 0;
    while (random_polls < RANDOM_POLLS) begin
      dis_phase = (phase % 5 == 3);
      configure($urandom_range(0, 40), $urandom_range(0, 150), $urandom_range(0, 500),
                1'($urandom), dis_phase);
      if (phase == 1)
        ts = 32'hFFFF_FE00;
      else if (phase % 3 == 0)
        ts = $urandom();
      target = dis_phase ? 20 : 60;
      while (poll_backlog.size() < target) begin
        case ($urandom_range(0, 5))
          0: add_press($urandom_range(0, shadow_cfg.tap_min_time));
          1, 2: add_press($urandom_range(shadow_cfg.tap_min_time, shadow_cfg.hold_time));
          3: add_press(shadow_cfg.hold_time + $urandom_range(0, 200));
          4: repeat ($urandom_range(1, 3)) poll_backlog.push_back('{1'($urandom), $urandom()});
          default: begin
            ts -= $urandom_range(1, 100);
            add_poll(1'($urandom), 0);
          end
        endcase
      end
      if (!dis_phase)
        random_polls += poll_backlog.size();
      // receiver holds off while the sender keeps offering
      if (phase == 2) begin
        steady_tx = 1'b1;
        hold_off_req = 1'b1;
      end
      drain();
      steady_tx = 1'b0;
      phase++;
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (button_reports.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, button_reports.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/btnc_pkg.sv
hdl/btnc_poll_if.sv
hdl/btnc_result_if.sv
hdl/btnc_cfg.sv
hdl/btnc_core.sv
hdl/button_tap_hold_classifier.sv
tb/button_tap_hold_classifier_test.sv
